FILE: rtl/core/ssc_pkg.sv
`default_nettype none

package ssc_pkg;

	// Item kinds carried in the input tuser field.
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_TEXT = 2'd1;
	localparam logic [1:0] OP_END  = 2'd2;

	// Fixed field widths.
	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 9;
	localparam int TOTAL_W = 32;

	// Controls broadcast from the sequencer to every compare cell.
	typedef struct packed {
		logic win_en;     // shift or rotate the text window by one cell
		logic flag_en;    // advance the prefix-match flags by one step
		logic flag_kill;  // force every prefix-match flag to zero
	} ssc_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/ssc_cell.sv
`default_nettype none

// One compare cell: holds a pattern byte, a window byte and the flag that says
// a pattern prefix ending at this cell's index matches the newest text bytes.
module ssc_cell (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire  ssc_pkg::ssc_ctrl_t        ctrl,
	input  wire                             load_en,
	input  wire  [ssc_pkg::BYTE_W-1:0]      bcast_byte,
	input  wire  [ssc_pkg::BYTE_W-1:0]      win_in,
	input  wire                             flag_in,
	output logic [ssc_pkg::BYTE_W-1:0]      win_out,
	output logic                            flag_out
);

	logic [ssc_pkg::BYTE_W-1:0] pat_q;
	logic [ssc_pkg::BYTE_W-1:0] win_q;
	logic                       flag_q;

	// Pattern byte and window byte are payload and need no reset.
	always_ff @(posedge clk) begin
		if (load_en) begin
			pat_q <= bcast_byte;
		end
		if (ctrl.win_en) begin
			win_q <= win_in;
		end
	end

	// The prefix flag extends the neighbour's flag by one matching byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (ctrl.flag_kill) begin
			flag_q <= 1'b0;
		end else if (ctrl.flag_en) begin
			flag_q <= flag_in && (bcast_byte == pat_q);
		end
	end

	assign win_out  = win_q;
	assign flag_out = flag_q;

endmodule

`default_nettype wire

FILE: rtl/core/substring_occurrence_counter.sv
// Channel        Direction  Signals                         Contents
// s_axis         in         tvalid tready tdata tuser       one item: kind, position, byte
// m_axis         out        tvalid tready tdata tuser       one result: total, flags
// pattern_length in         pattern_length_we pattern_length  pattern length register
//
// A text, end or unused item visits the idle and result states: the cell row steps at
// acceptance and the result is formed in the result state from the selected cell flag.
// A load into a non-empty window passes through the replay state, in which the window
// rotates once round the cell row and rebuilds the prefix flags against the new pattern.
// The result register lets the next item be accepted while a result is still waiting;
// a result that is not taken holds the block in its result cycle.
// Reset clears the flags, counters and sequencer; pattern and window bytes are not reset.
`default_nettype none

module substring_occurrence_counter #(
	parameter int MAX_PATTERN_LEN = 256
) (
	input  wire         clk,
	input  wire         arst_n,
	// Input items.
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [15:0] s_axis_tdata,   // [7:0] position, [15:8] data_byte
	input  wire  [1:0]  s_axis_tuser,   // [1:0] opcode
	// Result items.
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] match_total
	output logic [1:0]  m_axis_tuser,   // [0] match_here, [1] text_end
	// Configuration.
	input  wire         pattern_length_we,
	input  wire  [8:0]  pattern_length
);

	localparam int CNT_W = $clog2(MAX_PATTERN_LEN + 1);
	localparam int PTR_W = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_REPLAY = 2'd1;
	localparam logic [1:0] ST_FIN    = 2'd2;

	logic [1:0]                       state_q;
	logic [ssc_pkg::LEN_W-1:0]        len_q;
	logic [CNT_W-1:0]                 seen_q;
	logic [CNT_W-1:0]                 rp_q;
	logic [1:0]                       op_q;
	logic [ssc_pkg::TOTAL_W-1:0]      count_q;
	logic                             out_valid_q;
	logic                             here_q;
	logic                             end_q;
	logic [ssc_pkg::TOTAL_W-1:0]      total_q;

	logic [1:0]                       in_op;
	logic [7:0]                       in_pos;
	logic [ssc_pkg::BYTE_W-1:0]       in_byte;
	logic                             accept;
	logic                             is_text;
	logic                             is_end;
	logic                             is_load;
	logic                             pos_ok;
	logic                             need_replay;
	logic                             replaying;
	logic                             feed_ok;
	logic                             fin_go;
	logic                             hit;
	logic [CNT_W-1:0]                 len_eff;
	logic [PTR_W-1:0]                 sel;
	logic [ssc_pkg::BYTE_W-1:0]       win_last;
	logic [ssc_pkg::BYTE_W-1:0]       bcast;
	logic [ssc_pkg::TOTAL_W-1:0]      count_inc;
	ssc_pkg::ssc_ctrl_t               ctrl;

	logic [ssc_pkg::BYTE_W-1:0]       win [MAX_PATTERN_LEN];
	logic [MAX_PATTERN_LEN-1:0]       flags;

	// Input field unpacking and handshake.
	assign in_op         = s_axis_tuser;
	assign in_pos        = s_axis_tdata[7:0];
	assign in_byte       = s_axis_tdata[15:8];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_text       = accept && (in_op == ssc_pkg::OP_TEXT);
	assign is_end        = accept && (in_op == ssc_pkg::OP_END);
	assign is_load       = accept && (in_op == ssc_pkg::OP_LOAD);
	assign pos_ok        = ({24'd0, in_pos} < 32'(MAX_PATTERN_LEN));
	assign need_replay   = is_load && pos_ok && (seen_q != '0);
	assign replaying     = (state_q == ST_REPLAY);

	// During a rebuild only window bytes that were really seen feed the flags.
	assign feed_ok  = ({1'b0, rp_q} + {1'b0, seen_q}) >= (CNT_W + 1)'(MAX_PATTERN_LEN);
	assign win_last = win[MAX_PATTERN_LEN-1];
	assign bcast    = replaying ? win_last : in_byte;

	always_comb begin
		ctrl.win_en    = is_text || replaying;
		ctrl.flag_en   = is_text || replaying;
		ctrl.flag_kill = is_end || need_replay || (replaying && !feed_ok);
	end

	// Row of compare cells: window bytes and prefix flags pass to the next cell.
	for (genvar k = 0; k < MAX_PATTERN_LEN; k++) begin : g_cell
		logic [ssc_pkg::BYTE_W-1:0] w_in;
		logic                       f_in;
		logic                       ld;

		if (k == 0) begin : g_head
			assign w_in = bcast;
			assign f_in = 1'b1;
		end else begin : g_body
			assign w_in = win[k-1];
			assign f_in = flags[k-1];
		end

		assign ld = is_load && ({24'd0, in_pos} == 32'(k));

		ssc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.load_en    (ld),
			.bcast_byte (bcast),
			.win_in     (w_in),
			.flag_in    (f_in),
			.win_out    (win[k]),
			.flag_out   (flags[k])
		);
	end

	// Effective length, clamped to the cell row, selects the flag to report.
	always_comb begin
		if ({23'd0, len_q} > 32'(MAX_PATTERN_LEN)) begin
			len_eff = CNT_W'(MAX_PATTERN_LEN);
		end else begin
			len_eff = CNT_W'(len_q);
		end
		sel = PTR_W'(len_eff - 1'b1);
		hit = (op_q == ssc_pkg::OP_TEXT) && (len_eff != '0) && flags[sel];
	end

	assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;
	assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (pattern_length_we) begin
			len_q <= pattern_length;
		end
	end

	// Sequencer, window fill and running count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seen_q  <= '0;
			rp_q    <= '0;
			op_q    <= ssc_pkg::OP_LOAD;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q <= in_op;
						if (need_replay) begin
							rp_q    <= '0;
							state_q <= ST_REPLAY;
						end else begin
							state_q <= ST_FIN;
						end
						if (is_text && (seen_q != CNT_W'(MAX_PATTERN_LEN))) begin
							seen_q <= seen_q + 1'b1;
						end
						if (is_end) begin
							seen_q <= '0;
						end
					end
				end
				ST_REPLAY: begin
					rp_q <= rp_q + 1'b1;
					if (rp_q == CNT_W'(MAX_PATTERN_LEN - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
						if (hit) begin
							count_q <= count_inc;
						end else if (op_q == ssc_pkg::OP_END) begin
							count_q <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register: holds one finished item until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			here_q  <= hit;
			end_q   <= (op_q == ssc_pkg::OP_END);
			total_q <= hit ? count_inc : count_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = total_q;
	assign m_axis_tuser  = {end_q, here_q};

endmodule

`default_nettype wire

FILE: tb/sv/occurrence_checker.sv
`timescale 1ns / 100ps

module occurrence_checker #(
	parameter int MAX_PATTERN_LEN = 256
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	input  wire         s_axis_tready,
	input  wire  [15:0] s_axis_tdata,   // [7:0] position, [15:8] data_byte
	input  wire  [1:0]  s_axis_tuser,   // [1:0] opcode
	input  wire         m_axis_tvalid,
	input  wire         m_axis_tready,
	input  wire  [31:0] m_axis_tdata,   // [31:0] match_total
	input  wire  [1:0]  m_axis_tuser,   // [0] match_here, [1] text_end
	input  wire         pattern_length_we,
	input  wire  [8:0]  pattern_length,
	output int          mismatches,
	output int          pending
);

	typedef struct packed {
		logic                        here;
		logic [ssc_pkg::TOTAL_W-1:0] total;
		logic                        text_end;
	} count_result_t;

	// Own copy of the pattern, the text window and the counters.
	logic [ssc_pkg::BYTE_W-1:0]  pat_bytes [MAX_PATTERN_LEN];
	logic [ssc_pkg::BYTE_W-1:0]  win_bytes [MAX_PATTERN_LEN];
	int                          win_ptr;
	int                          win_fill;
	logic [ssc_pkg::TOTAL_W-1:0] occ_count;
	logic [ssc_pkg::LEN_W-1:0]   cur_len;

	count_result_t awaited_q [$];
	count_result_t fresh;
	count_result_t want;
	int            fail_total;

	// True when the newest bytes of the window equal the pattern in use.
	function automatic bit window_hits();
		int len;
		int first;
		len = (cur_len > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : int'(cur_len);
		if (len == 0 || win_fill < len)
			return 1'b0;
		first = (win_ptr + MAX_PATTERN_LEN - len) % MAX_PATTERN_LEN;
		for (int k = 0; k < len; k++)
			if (win_bytes[(first + k) % MAX_PATTERN_LEN] !== pat_bytes[k])
				return 1'b0;
		return 1'b1;
	endfunction

	// Advances the predicted state by one item and forms its result.
	task automatic predict_item(input logic [1:0] kind, input logic [7:0] pos,
			input logic [7:0] val, output count_result_t res);
		res.here = 1'b0;
		res.text_end = 1'b0;
		res.total = occ_count;
		case (kind)
			ssc_pkg::OP_LOAD: begin
				if (int'(pos) < MAX_PATTERN_LEN)
					pat_bytes[pos] = val;
			end
			ssc_pkg::OP_TEXT: begin
				win_bytes[win_ptr] = val;
				win_ptr = (win_ptr + 1) % MAX_PATTERN_LEN;
				if (win_fill < MAX_PATTERN_LEN)
					win_fill++;
				if (window_hits()) begin
					res.here = 1'b1;
					if (occ_count != '1)
						occ_count++;
				end
				res.total = occ_count;
			end
			ssc_pkg::OP_END: begin
				res.text_end = 1'b1;
				occ_count = '0;
				win_fill = 0;
			end
			default: begin
			end
		endcase
	endtask

	// Watch both channels and the register port, predict and compare.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_ptr = 0;
			win_fill = 0;
			occ_count = '0;
			cur_len = '0;
			fail_total = 0;
			awaited_q.delete();
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (pattern_length_we)
				cur_len = pattern_length;
			if (s_axis_tvalid && s_axis_tready) begin
				predict_item(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8], fresh);
				awaited_q.push_back(fresh);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_q.size() == 0) begin
					fail_total++;
					if (fail_total <= 10)
						$display("%0t: result with none awaited: here %0b total %0d end %0b",
							$time, m_axis_tuser[0], m_axis_tdata, m_axis_tuser[1]);
				end else begin
					want = awaited_q.pop_front();
					if (want.here !== m_axis_tuser[0] || want.total !== m_axis_tdata ||
							want.text_end !== m_axis_tuser[1]) begin
						fail_total++;
						if (fail_total <= 10) begin
							$write("%0t: mismatch: expected here %0b total %0d end %0b,",
								$time, want.here, want.total, want.text_end);
							$display(" got here %0b total %0d end %0b", m_axis_tuser[0],
								m_axis_tdata, m_axis_tuser[1]);
						end
					end
				end
			end
			mismatches <= fail_total;
			pending <= awaited_q.size();
		end
	end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int MAX_LEN       = 256;
	localparam int SETTLE_CYCLES = MAX_LEN + 8;
	localparam int RANDOM_ITEMS  = 1100;
	localparam int HOLD_CYCLES   = 400;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	wire         s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = ssc_pkg::OP_LOAD;
	wire         m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire  [31:0] m_axis_tdata;
	wire  [1:0]  m_axis_tuser;
	logic        pattern_length_we = 1'b0;
	logic [8:0]  pattern_length = '0;

	int mismatches;
	int pending;

	// Shared controls for idling and the long receiver hold-off.
	bit no_idle = 1'b0;
	int hold_token = 0;
	int hold_seen = 0;
	int hold_left = 0;

	// Copy of what has been loaded, so that text can repeat the pattern.
	logic [7:0] pat_shadow [MAX_LEN];
	bit         pat_loaded [MAX_LEN];
	bit         full_loaded = 1'b0;
	int         items_sent = 0;

	substring_occurrence_counter #(
		.MAX_PATTERN_LEN(MAX_LEN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.pattern_length_we(pattern_length_we),
		.pattern_length(pattern_length)
	);

	occurrence_checker #(
		.MAX_PATTERN_LEN(MAX_LEN)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.pattern_length_we(pattern_length_we),
		.pattern_length(pattern_length),
		.mismatches(mismatches),
		.pending(pending)
	);

	// Clock of 20 ns.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Guard against a hung run.
	initial begin
		#50_000_000;
		$display("testbench failed");
		$finish;
	end

	// Receiver: random stalls, a quiet stretch, and one long hold-off on request.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_token) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (no_idle) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= 30);
		end
	end

	// Offers one item after a random gap and waits until it is taken.
	task automatic send_item(input logic [1:0] kind, input logic [7:0] pos,
			input logic [7:0] val);
		while (!no_idle && $urandom_range(99) < 30) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {val, pos};
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (kind != OP_UNUSED)
			items_sent++;
	endtask

	task automatic load_byte(input int pos, input logic [7:0] val);
		send_item(ssc_pkg::OP_LOAD, pos[7:0], val);
		pat_shadow[pos] = val;
		pat_loaded[pos] = 1'b1;
	endtask

	// The position field is ignored on text items, so it carries noise.
	task automatic text_byte(input logic [7:0] val);
		send_item(ssc_pkg::OP_TEXT, 8'($urandom_range(255)), val);
	endtask

	// Stops offering, waits for every result, then lets a rotation finish.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_length(input logic [8:0] value);
		pattern_length_we <= 1'b1;
		pattern_length <= value;
		@(posedge clk);
		pattern_length_we <= 1'b0;
	endtask

	// A small alphabet with both extremes, so that matches are frequent.
	function automatic logic [7:0] pick_symbol();
		case ($urandom_range(2))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'h5A;
		endcase
	endfunction

	// Stimulus.
	initial begin
		int round;
		int len;
		int act;
		int steps;
		int choice;
		int w;
		int directed_count;

		for (int k = 0; k < MAX_LEN; k++)
			pat_loaded[k] = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero length never matches; an unused opcode changes nothing.
		send_item(ssc_pkg::OP_TEXT, 8'hFF, 8'h41);
		send_item(ssc_pkg::OP_TEXT, 8'h00, 8'h00);
		send_item(OP_UNUSED, 8'hFF, 8'hFF);
		load_byte(0, 8'h00);
		load_byte(1, 8'hFF);
		load_byte(2, 8'h00);
		load_byte(255, 8'hFF);
		send_item(ssc_pkg::OP_END, 8'h00, 8'h00);
		settle();
		set_length(9'd3);

		// Overlapping occurrences, then the total across an end item.
		text_byte(8'h00);
		text_byte(8'hFF);
		text_byte(8'h00);
		text_byte(8'hFF);
		text_byte(8'h00);
		send_item(OP_UNUSED, 8'h00, 8'h5A);
		send_item(ssc_pkg::OP_END, 8'hFF, 8'hFF);

		// Short window after an end item: old bytes must not count.
		text_byte(8'hFF);
		text_byte(8'h00);
		text_byte(8'hFF);
		text_byte(8'h00);
		settle();
		set_length(9'd1);
		text_byte(8'h00);
		text_byte(8'hFF);
		send_item(ssc_pkg::OP_END, 8'h00, 8'h00);
		directed_count = items_sent;

		// Random rounds: a length, a pattern, then text with noise.
		round = 0;
		while (items_sent < directed_count + RANDOM_ITEMS) begin
			settle();
			if (round == 1)
				no_idle <= 1'b1;
			if (round == 3)
				no_idle <= 1'b0;

			if (round == 3) begin
				// Full-length pattern of period two, then a length beyond the store.
				set_length(9'(MAX_LEN));
				for (int k = 0; k < MAX_LEN; k++)
					load_byte(k, k[0] ? 8'hC3 : 8'h3C);
				for (int k = 0; k < MAX_LEN; k++)
					text_byte(pat_shadow[k]);
				text_byte(pat_shadow[0]);
				text_byte(pat_shadow[1]);
				settle();
				set_length(9'h1FF);
				text_byte(pat_shadow[0]);
				text_byte(pat_shadow[1]);
				text_byte(8'h5A);
				send_item(ssc_pkg::OP_END, 8'($urandom_range(255)),
					8'($urandom_range(255)));
				full_loaded = 1'b1;
			end else begin
				choice = $urandom_range(99);
				if (choice < 10)
					len = 0;
				else if (choice < 70)
					len = $urandom_range(1, 4);
				else if (choice < 92)
					len = $urandom_range(5, 12);
				else if (full_loaded)
					len = $urandom_range(511);
				else
					len = $urandom_range(1, 16);
				act = (len > MAX_LEN) ? MAX_LEN : len;
				set_length(len[8:0]);
				if (round == 6)
					hold_token <= hold_token + 1;

				// Every pattern byte inside the length must be loaded before use.
				for (int k = 0; k < act; k++)
					if (!pat_loaded[k])
						load_byte(k, pick_symbol());
				if (act <= 16 && $urandom_range(1))
					for (int k = 0; k < act; k++)
						load_byte(k, pick_symbol());

				steps = $urandom_range(10, 40);
				for (int s = 0; s < steps; s++) begin
					choice = $urandom_range(99);
					if (choice < 45 && act > 0 && act <= 16) begin
						for (int k = 0; k < act; k++)
							text_byte(pat_shadow[k]);
					end else if (choice < 85) begin
						text_byte(pick_symbol());
					end else if (choice < 91) begin
						text_byte(8'($urandom_range(255)));
					end else if (choice < 95) begin
						load_byte($urandom_range(255), pick_symbol());
					end else if (choice < 98) begin
						send_item(OP_UNUSED, 8'($urandom_range(255)),
							8'($urandom_range(255)));
					end else begin
						send_item(ssc_pkg::OP_END, 8'($urandom_range(255)),
							8'($urandom_range(255)));
					end
				end
				if ($urandom_range(99) < 60)
					send_item(ssc_pkg::OP_END, 8'($urandom_range(255)),
						8'($urandom_range(255)));
			end
			round++;
		end

		// Drain with a bound, then give the verdict.
		s_axis_tvalid <= 1'b0;
		for (w = 0; w < 200000 && pending != 0; w++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/ssc_pkg.sv
rtl/core/ssc_cell.sv
rtl/core/substring_occurrence_counter.sv
tb/sv/occurrence_checker.sv
tb/sv/testbench.sv
